// ===== src/bms_pkg.sv =====
// types and constants shared by the body motion step block
// no dependencies
package bms_pkg;

    localparam int GRAV_CM = 980;

    localparam logic [1:0] CFG_MASS = 2'd0;
    localparam logic [1:0] CFG_MU   = 2'd1;
    localparam logic [1:0] CFG_SIN  = 2'd2;
    localparam logic [1:0] CFG_COS  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_DIVX,
        ST_DIVY,
        ST_FRIC,
        ST_VEL,
        ST_DISP,
        ST_POS,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the input word
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic div_sel_y;
        logic fric;
        logic vel;
        logic disp;
        logic pos;
        logic hold;     // zero mass: keep state, flag
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_load;
        logic zero_mass;
        logic zero_vel;
        logic sqrt_done;
        logic div_done;
    } t_status;

endpackage

// ===== src/bms_if.sv =====
// valid/ready channel interfaces for the body motion step block
// depends on nothing
interface bms_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] time_step;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    modport source (output valid, action, time_step, load_pos_x, load_pos_y,
                    load_vel_x, load_vel_y, input ready);
    modport sink (input valid, action, time_step, load_pos_x, load_pos_y,
                  load_vel_x, load_vel_y, output ready);
endinterface

interface bms_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] pos_out_x;
    logic signed [31:0] pos_out_y;
    logic signed [31:0] vel_out_x;
    logic signed [31:0] vel_out_y;
    logic        saturated;
    modport source (output valid, disp_x, disp_y, pos_out_x, pos_out_y,
                    vel_out_x, vel_out_y, saturated, input ready);
    modport sink (input valid, disp_x, disp_y, pos_out_x, pos_out_y,
                  vel_out_x, vel_out_y, saturated, output ready);
endinterface

interface bms_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/body_motion_step_with_friction.sv =====
// top level of the body motion step block: config registers, controller, datapath
// depends on bms_pkg, bms_if, bms_ctrl, bms_dp
//
// usage: each input word is a step (action 0, dt) or a load (action 1, new
// position and velocity); each gives exactly one output word with the
// displacement, updated position and velocity and a saturation flag.
// config channel writes body_mass, friction_coefficient, incline_sine and
// incline_cosine by index 0..3; other indexes are ignored. write only when idle.
// steps from the accepting edge to the output word: a load or a zero-mass step
// goes straight to the output state; a step at zero velocity runs the velocity,
// displacement and position updates; a moving step first runs the root and the
// restoring x and y divides, one bit per cycle each, then friction and updates.
// one word is worked at a time; the next is taken the cycle after the result
// is loaded into the output register.
// reset: position and velocity cleared, registers to their reset values.
// a stalled receiver holds the output word; the block finishes the next item
// and waits to load it until the old word is taken.
module body_motion_step_with_friction import bms_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bms_in_if.sink    in_ch,
    bms_out_if.source out_ch,
    bms_cfg_if.sink   cfg_ch
);
    logic [31:0]        r_body_mass;
    logic [15:0]        r_friction_coefficient;
    logic signed [15:0] r_incline_sine;
    logic signed [15:0] r_incline_cosine;
    t_cmd    w_cmd;
    t_status w_status;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_mass            <= 32'd65536;
            r_friction_coefficient <= 16'd0;
            r_incline_sine         <= 16'sd0;
            r_incline_cosine       <= 16'sd32767;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                CFG_MASS: r_body_mass            <= cfg_ch.data;
                CFG_MU:   r_friction_coefficient <= cfg_ch.data[15:0];
                CFG_SIN:  r_incline_sine         <= cfg_ch.data[15:0];
                CFG_COS:  r_incline_cosine       <= cfg_ch.data[15:0];
                default: ;
            endcase
        end
    end

    bms_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    bms_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_status(w_status),
        .i_action(in_ch.action), .i_time_step(in_ch.time_step),
        .i_load_pos_x(in_ch.load_pos_x), .i_load_pos_y(in_ch.load_pos_y),
        .i_load_vel_x(in_ch.load_vel_x), .i_load_vel_y(in_ch.load_vel_y),
        .i_body_mass(r_body_mass), .i_friction_coefficient(r_friction_coefficient),
        .i_incline_sine(r_incline_sine), .i_incline_cosine(r_incline_cosine),
        .o_disp_x(out_ch.disp_x), .o_disp_y(out_ch.disp_y),
        .o_pos_out_x(out_ch.pos_out_x), .o_pos_out_y(out_ch.pos_out_y),
        .o_vel_out_x(out_ch.vel_out_x), .o_vel_out_y(out_ch.vel_out_y),
        .o_saturated(out_ch.saturated)
    );

    // a load never reports saturation
    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load && w_status.is_load |=> !out_ch.saturated)
        else $error("load word flagged saturated");

    // no new word accepted while one is being worked
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input taken twice in a row");

    // the output register is only reloaded when free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!out_ch.valid || out_ch.ready))
        else $error("output word overwritten");
endmodule

// ===== src/bms_ctrl.sv =====
// controller state machine for the body motion step block
// depends on bms_pkg
module bms_ctrl import bms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // first cycle here after capture: decide the path
                if (i_status.is_load) begin
                    n_state = ST_OUT;
                end else if (i_status.zero_mass) begin
                    o_cmd.hold = 1'b1;
                    n_state    = ST_OUT;
                end else if (i_status.zero_vel) begin
                    n_state = ST_VEL;
                end else begin
                    o_cmd.sqrt_init = 1'b1;
                    n_state         = ST_DIVX;
                end
            end
            ST_DIVX: begin
                // root runs, then x division
                if (!i_status.sqrt_done) begin
                    o_cmd.sqrt_step = 1'b1;
                end else if (!i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.div_init  = 1'b1;
                    o_cmd.div_sel_y = 1'b1;
                    n_state         = ST_DIVY;
                end
            end
            ST_DIVY: begin
                o_cmd.div_sel_y = 1'b1;
                if (!i_status.div_done) begin
                    o_cmd.div_step  = 1'b1;
                end else begin
                    n_state = ST_FRIC;
                end
            end
            ST_FRIC: begin
                o_cmd.fric = 1'b1;
                n_state    = ST_VEL;
            end
            ST_VEL: begin
                o_cmd.vel = 1'b1;
                n_state   = ST_DISP;
            end
            ST_DISP: begin
                o_cmd.disp = 1'b1;
                n_state    = ST_POS;
            end
            ST_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== src/bms_dp.sv =====
// datapath: state registers, root and divide units, force and update math
// depends on bms_pkg
module bms_dp import bms_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_action,
    input  logic [15:0] i_time_step,
    input  logic signed [31:0] i_load_pos_x,
    input  logic signed [31:0] i_load_pos_y,
    input  logic signed [31:0] i_load_vel_x,
    input  logic signed [31:0] i_load_vel_y,
    input  logic [31:0] i_body_mass,
    input  logic [15:0] i_friction_coefficient,
    input  logic signed [15:0] i_incline_sine,
    input  logic signed [15:0] i_incline_cosine,
    output logic signed [31:0] o_disp_x,
    output logic signed [31:0] o_disp_y,
    output logic signed [31:0] o_pos_out_x,
    output logic signed [31:0] o_pos_out_y,
    output logic signed [31:0] o_vel_out_x,
    output logic signed [31:0] o_vel_out_y,
    output logic        o_saturated
);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] GRAV = 64'(GRAV_CM);
    localparam logic signed [63:0] SMAX = 64'sd2147483647;
    localparam logic signed [63:0] SMIN = -64'sd2147483648;

    logic signed [31:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y;
    logic               r_action;
    logic [15:0]        r_dt;
    logic signed [31:0] r_lpx, r_lpy, r_lvx, r_lvy;
    logic signed [31:0] r_dx, r_dy;
    logic signed [31:0] r_nvx, r_nvy;
    logic               r_sat;
    logic signed [63:0] r_ax, r_ay;

    // sqrt unit, one result bit per cycle
    logic [63:0] r_sq_x, r_sq_r, r_sq_bit;
    logic [31:0] r_len;
    // divide unit, restoring, one quotient bit per cycle
    logic [47:0] r_dv_num;
    logic [47:0] r_dv_rem;
    logic [47:0] r_quo;
    logic [5:0]  r_dv_cnt;
    logic        r_dv_busy;
    logic [47:0] r_ux;

    logic [31:0] w_mx, w_my;
    assign w_mx = r_vel_x[31] ? 32'(-r_vel_x) : 32'(r_vel_x);
    assign w_my = r_vel_y[31] ? 32'(-r_vel_y) : 32'(r_vel_y);

    assign o_status.is_load   = r_action;
    assign o_status.zero_mass = (i_body_mass == 32'd0);
    assign o_status.zero_vel  = (r_vel_x == 32'sd0) && (r_vel_y == 32'sd0);
    assign o_status.sqrt_done = (r_sq_bit == 64'd0);
    assign o_status.div_done  = !r_dv_busy;

    function automatic logic signed [63:0] fshift(input logic signed [63:0] v,
                                                  input int n);
        fshift = v >>> n;
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > SMAX)      sat = 32'sh7fffffff;
        else if (v < SMIN) sat = 32'sh80000000;
        else               sat = v[31:0];
    endfunction

    function automatic logic ovf(input logic signed [63:0] v);
        ovf = (v > SMAX) || (v < SMIN);
    endfunction

    // gravity terms, mult by constant
    logic signed [63:0] w_gx, w_gy;
    assign w_gx = fshift(GRAV * 64'(i_incline_sine) * ONE, 15);
    assign w_gy = fshift(GRAV * 64'(i_incline_cosine) * ONE, 15) - GRAV * ONE;

    logic [63:0] w_fm;
    assign w_fm = ((64'(i_friction_coefficient) * GRAV) << FRAC_BITS) >> 12;

    logic [63:0] w_sq_sum;
    assign w_sq_sum = 64'(w_mx) * 64'(w_mx) + 64'(w_my) * 64'(w_my);

    logic signed [63:0] w_vx_new, w_vy_new, w_dx, w_dy, w_px, w_py;
    logic signed [63:0] w_fx, w_fy;
    logic [47:0] w_dv_trial;
    assign w_dv_trial = {r_dv_rem[46:0], r_dv_num[47]};

    always_comb begin
        w_fx = $signed((w_fm * 64'(r_ux)) >> 15);
        // y quotient is still in the divider when the forces are formed
        w_fy = $signed((w_fm * 64'(r_quo)) >> 15);
        w_vx_new = 64'(r_vel_x) + fshift(r_ax * $signed(64'(r_dt)), 16);
        w_vy_new = 64'(r_vel_y) + fshift(r_ay * $signed(64'(r_dt)), 16);
        w_dx = fshift((64'(r_vel_x) + 64'(r_nvx)) * $signed(64'(r_dt)), 17);
        w_dy = fshift((64'(r_vel_y) + 64'(r_nvy)) * $signed(64'(r_dt)), 17);
        w_px = 64'(r_pos_x) + 64'(r_dx);
        w_py = 64'(r_pos_y) + 64'(r_dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_vel_x   <= '0;
            r_vel_y   <= '0;
            r_action  <= 1'b0;
            r_dv_busy <= 1'b0;
            r_sq_bit  <= '0;
            r_sat     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_action <= i_action;
                r_dt     <= i_time_step;
                r_lpx    <= i_load_pos_x;
                r_lpy    <= i_load_pos_y;
                r_lvx    <= i_load_vel_x;
                r_lvy    <= i_load_vel_y;
                r_sat    <= 1'b0;
                r_dx     <= '0;
                r_dy     <= '0;
                r_ux     <= '0;
                r_sq_bit <= '0;
            end
            if (i_cmd.hold) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.sqrt_init) begin
                r_sq_x   <= w_sq_sum;
                r_sq_r   <= '0;
                r_sq_bit <= 64'd1 << 62;
            end
            if (i_cmd.sqrt_step) begin
                // skip leading bit pairs above the operand, then one digit per cycle
                if (r_sq_bit > r_sq_x && r_sq_r == 64'd0) begin
                    r_sq_bit <= r_sq_bit >> 2;
                end else begin
                    if (r_sq_x >= r_sq_r + r_sq_bit) begin
                        r_sq_x <= r_sq_x - (r_sq_r + r_sq_bit);
                        r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        r_sq_r <= r_sq_r >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    if ((r_sq_bit >> 2) == 64'd0) begin
                        r_len     <= (r_sq_x >= r_sq_r + r_sq_bit) ?
                                     32'((r_sq_r >> 1) + r_sq_bit) : 32'(r_sq_r >> 1);
                        r_dv_num  <= {w_mx, 15'd0, 1'b0} >> 1;
                        r_dv_rem  <= '0;
                        r_quo     <= '0;
                        r_dv_cnt  <= 6'd47;
                        r_dv_busy <= 1'b1;
                    end
                end
            end
            if (i_cmd.div_init) begin
                r_ux      <= r_quo;
                r_dv_num  <= {1'b0, w_my, 15'd0};
                r_dv_rem  <= '0;
                r_quo     <= '0;
                r_dv_cnt  <= 6'd47;
                r_dv_busy <= 1'b1;
            end
            if (i_cmd.div_step) begin
                r_dv_num <= {r_dv_num[46:0], 1'b0};
                if (w_dv_trial >= {16'd0, r_len}) begin
                    r_dv_rem <= w_dv_trial - {16'd0, r_len};
                    r_quo    <= {r_quo[46:0], 1'b1};
                end else begin
                    r_dv_rem <= w_dv_trial;
                    r_quo    <= {r_quo[46:0], 1'b0};
                end
                if (r_dv_cnt == 6'd0) begin
                    r_dv_busy <= 1'b0;
                end else begin
                    r_dv_cnt <= r_dv_cnt - 6'd1;
                end
            end
            if (i_cmd.fric) begin
                r_ax <= w_gx - (r_vel_x > 0 ? w_fx : (r_vel_x < 0 ? -w_fx : 64'sd0));
                r_ay <= w_gy - (r_vel_y > 0 ? w_fy : (r_vel_y < 0 ? -w_fy : 64'sd0));
            end
            if (i_cmd.vel) begin
                if (o_status.zero_vel) begin
                    r_ax <= w_gx;
                    r_ay <= w_gy;
                    r_nvx <= sat(64'(r_vel_x) + fshift(w_gx * $signed(64'(r_dt)), 16));
                    r_nvy <= sat(64'(r_vel_y) + fshift(w_gy * $signed(64'(r_dt)), 16));
                    r_sat <= r_sat
                        | ovf(64'(r_vel_x) + fshift(w_gx * $signed(64'(r_dt)), 16))
                        | ovf(64'(r_vel_y) + fshift(w_gy * $signed(64'(r_dt)), 16));
                end else begin
                    r_nvx <= sat(w_vx_new);
                    r_nvy <= sat(w_vy_new);
                    r_sat <= r_sat | ovf(w_vx_new) | ovf(w_vy_new);
                end
            end
            if (i_cmd.disp) begin
                r_dx    <= sat(w_dx);
                r_dy    <= sat(w_dy);
                r_sat   <= r_sat | ovf(w_dx) | ovf(w_dy);
                r_vel_x <= r_nvx;
                r_vel_y <= r_nvy;
            end
            if (i_cmd.pos) begin
                r_pos_x <= sat(w_px);
                r_pos_y <= sat(w_py);
                r_sat   <= r_sat | ovf(w_px) | ovf(w_py);
            end
            if (i_cmd.out_load && r_action) begin
                r_pos_x <= r_lpx;
                r_pos_y <= r_lpy;
                r_vel_x <= r_lvx;
                r_vel_y <= r_lvy;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_disp_x    <= r_dx;
            o_disp_y    <= r_dy;
            o_pos_out_x <= r_action ? r_lpx : r_pos_x;
            o_pos_out_y <= r_action ? r_lpy : r_pos_y;
            o_vel_out_x <= r_action ? r_lvx : r_vel_x;
            o_vel_out_y <= r_action ? r_lvy : r_vel_y;
            o_saturated <= r_sat;
        end
    end
endmodule

// ===== verif/bms_checker.sv =====
// checker for the body motion step block: watches the step, result and config channels
// depends on bms_pkg and bms_if; predicts each result word and compares it field by field
module bms_checker import bms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bms_in_if.sink  in_mon,
    bms_out_if.sink out_mon,
    bms_cfg_if.sink cfg_mon,
    output int      o_fail_count,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] dx, dy, px, py, vx, vy;
        logic               sat;
    } t_motion;

    t_motion expected_words[$];

    logic [31:0]        mass_q;
    logic [15:0]        mu_q;
    logic signed [15:0] sin_q, cos_q;
    longint             pos_xs, pos_ys, vel_xs, vel_ys;

    function automatic longint clip32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // >>> on a signed longint is an arithmetic shift, i.e. floor
    function automatic longint int_root(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic t_motion advance_body(input logic act, input logic [15:0] dt_in,
                                             input logic signed [31:0] lpx, lpy, lvx, lvy);
        t_motion w;
        bit sat;
        longint ax, ay, dt, nvx, nvy, dx, dy;
        longint unsigned mx, my, len, fm, fx, fy;
        sat = 0;
        dx = 0;
        dy = 0;
        if (act) begin
            pos_xs = lpx;
            pos_ys = lpy;
            vel_xs = lvx;
            vel_ys = lvy;
        end else if (mass_q == 0) begin
            sat = 1;
        end else begin
            dt = dt_in;
            ax = (longint'(GRAV_CM) * sin_q * 65536) >>> 15;
            ay = ((longint'(GRAV_CM) * cos_q * 65536) >>> 15) - longint'(GRAV_CM) * 65536;
            mx = vel_xs < 0 ? -vel_xs : vel_xs;
            my = vel_ys < 0 ? -vel_ys : vel_ys;
            if (mx != 0 || my != 0) begin
                len = int_root(mx * mx + my * my);
                fm = ((longint'(mu_q) * GRAV_CM) << 16) >> 12;
                fx = (fm * ((mx << 15) / len)) >> 15;
                fy = (fm * ((my << 15) / len)) >> 15;
                if (vel_xs > 0) ax -= fx;
                else if (vel_xs < 0) ax += fx;
                if (vel_ys > 0) ay -= fy;
                else if (vel_ys < 0) ay += fy;
            end
            nvx = clip32(vel_xs + ((ax * dt) >>> 16), sat);
            nvy = clip32(vel_ys + ((ay * dt) >>> 16), sat);
            dx = clip32(((vel_xs + nvx) * dt) >>> 17, sat);
            dy = clip32(((vel_ys + nvy) * dt) >>> 17, sat);
            vel_xs = nvx;
            vel_ys = nvy;
            pos_xs = clip32(pos_xs + dx, sat);
            pos_ys = clip32(pos_ys + dy, sat);
        end
        w.dx = dx[31:0];
        w.dy = dy[31:0];
        w.px = pos_xs[31:0];
        w.py = pos_ys[31:0];
        w.vx = vel_xs[31:0];
        w.vy = vel_ys[31:0];
        w.sat = sat;
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d (%h), got %0d (%h)", $time, name,
                     $signed(exp_v), exp_v, $signed(act_v), act_v);
            o_fail_count++;
        end
    endtask

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_motion e;
        if (!i_rst_n) begin
            mass_q <= 32'd65536;
            mu_q <= '0;
            sin_q <= '0;
            cos_q <= 16'sd32767;
            pos_xs = 0;
            pos_ys = 0;
            vel_xs = 0;
            vel_ys = 0;
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.index)
                    CFG_MASS: mass_q <= cfg_mon.data;
                    CFG_MU: mu_q <= cfg_mon.data[15:0];
                    CFG_SIN: sin_q <= cfg_mon.data[15:0];
                    CFG_COS: cos_q <= cfg_mon.data[15:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                expected_words.push_back(advance_body(in_mon.action, in_mon.time_step,
                    in_mon.load_pos_x, in_mon.load_pos_y, in_mon.load_vel_x, in_mon.load_vel_y));
            if (out_mon.valid && out_mon.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected", $time);
                    o_fail_count++;
                end else begin
                    e = expected_words.pop_front();
                    check_field("disp_x", e.dx, out_mon.disp_x);
                    check_field("disp_y", e.dy, out_mon.disp_y);
                    check_field("pos_out_x", e.px, out_mon.pos_out_x);
                    check_field("pos_out_y", e.py, out_mon.pos_out_y);
                    check_field("vel_out_x", e.vx, out_mon.vel_out_x);
                    check_field("vel_out_y", e.vy, out_mon.vel_out_y);
                    check_field("saturated", {31'd0, e.sat}, {31'd0, out_mon.saturated});
                end
            end
        end
    end
endmodule

// ===== verif/body_motion_step_with_friction_tb.sv =====
// testbench top for body_motion_step_with_friction: clock, reset, stimulus, verdict
// depends on bms_pkg, bms_if, bms_checker and the block itself
module body_motion_step_with_friction_tb;
    import bms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   stall_heavy;

    bms_in_if  in_ch();
    bms_out_if out_ch();
    bms_cfg_if cfg_ch();

    body_motion_step_with_friction DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    bms_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_mon(in_ch), .out_mon(out_ch),
        .cfg_mon(cfg_ch), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // receiver: runs of free flow and runs of heavy stalling
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_heavy <= ~stall_heavy;
        out_ch.ready <= stall_heavy ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // valid stays high across back-to-back writes; set_body drops it
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        if (in_ch.valid) in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic set_body(input logic [31:0] m, input logic [15:0] mu,
                            input logic [15:0] s, input logic [15:0] c);
        drain_results();
        write_reg(CFG_MASS, m);
        write_reg(CFG_MU, mu);
        write_reg(CFG_SIN, s);
        write_reg(CFG_COS, c);
        cfg_ch.valid <= 1'b0;
    endtask

    // one word, then a random gap at the end of a burst
    task automatic send_word(input logic act, input logic [15:0] dt,
                             input logic [31:0] px, py, vx, vy, input bit gap);
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.time_step <= dt;
        in_ch.load_pos_x <= px;
        in_ch.load_pos_y <= py;
        in_ch.load_vel_x <= vx;
        in_ch.load_vel_y <= vy;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (gap) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end
    endtask

    task automatic random_word(input bit gap);
        logic [31:0] v [4];
        int k;
        for (k = 0; k < 4; k++) begin
            case ($urandom_range(0, 4))
                0: v[k] = $urandom;
                1: v[k] = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
                2: v[k] = 32'd0;
                default: v[k] = $signed($urandom_range(0, 20000000)) - 10000000;
            endcase
        end
        if ($urandom_range(0, 5) == 0)
            send_word(1'b1, 16'($urandom), v[0], v[1], v[2], v[3], gap);
        else
            send_word(1'b0, 16'($urandom), $urandom, $urandom, $urandom, $urandom, gap);
    endtask

    initial begin
        int n, phase;
        i_rst_n = 1'b0;
        stall_heavy = 1'b0;
        out_ch.ready = 1'b1;
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.time_step = '0;
        in_ch.load_pos_x = '0;
        in_ch.load_pos_y = '0;
        in_ch.load_vel_x = '0;
        in_ch.load_vel_y = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_MASS;
        cfg_ch.data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, at rest, then extremes and loads
        send_word(1'b0, 16'hffff, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        send_word(1'b0, 16'h0000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_word(1'b1, 16'h0000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  1'b0);
        send_word(1'b0, 16'hffff, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_word(1'b1, 16'hffff, 32'hffffffff, 32'h0, 32'h80000000, 32'h7fffffff, 1'b1);
        send_word(1'b0, 16'h8000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        set_body(32'hffffffff, 16'hffff, 16'h7fff, 16'h8000);
        send_word(1'b1, 16'h0000, 32'd0, 32'd0, 32'h00010000, 32'hfffe0000, 1'b0);
        send_word(1'b0, 16'h1000, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_word(1'b0, 16'hffff, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_word(1'b1, 16'h0000, 32'd0, 32'd0, 32'd1, 32'd0, 1'b0);
        send_word(1'b0, 16'h0001, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        set_body(32'd0, 16'h1000, 16'h8000, 16'h7fff);
        send_word(1'b0, 16'hffff, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        send_word(1'b1, 16'h0000, 32'd5, 32'd6, 32'd7, 32'd8, 1'b0);
        send_word(1'b0, 16'h1234, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);

        // pause until every expected result is in, then random phases
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_body(32'd65536, 16'd0, 16'd0, 16'h7fff);
                1: set_body($urandom, 16'($urandom), 16'($urandom), 16'($urandom));
                2: set_body(32'd1, 16'h0800, 16'h4000, 16'h6ed9);
                3: set_body(32'd0, 16'($urandom), 16'($urandom), 16'($urandom));
                4: set_body(32'hffffffff, 16'hffff, 16'h8000, 16'h7fff);
                default: set_body($urandom, 16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            for (n = 0; n < 120; n++)
                random_word($urandom_range(0, 7) == 0);
        end

        drain_results();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
